// ----- src/pab_pkg.sv -----
`default_nettype none

package pab_pkg;

    // Default sizes of the overlay store and the frame
    localparam int OVERLAY_MAX_WIDTH  = 256;
    localparam int OVERLAY_MAX_HEIGHT = 256;
    localparam int FRAME_MAX_DIM      = 4096;

    // Widest configuration register
    localparam int CFG_DATA_W = 13;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_BLEND = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        CFG_LEFT   = 2'd0,
        CFG_TOP    = 2'd1,
        CFG_WIDTH  = 2'd2,
        CFG_HEIGHT = 2'd3
    } t_cfg_index;

    typedef struct packed {
        t_opcode     opcode;
        logic [11:0] column;
        logic [11:0] row;
        logic [7:0]  blue_in;
        logic [7:0]  green_in;
        logic [7:0]  red_in;
        logic [7:0]  alpha_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0] blue_out;
        logic [7:0] green_out;
        logic [7:0] red_out;
    } t_out_item;

    // Overlay window registers
    typedef struct packed {
        logic signed [12:0] left;
        logic signed [12:0] top;
        logic [8:0]         width;
        logic [8:0]         height;
    } t_cfg;

    // Classified command handed from front to back (store address travels beside it)
    typedef struct packed {
        logic       is_load;
        logic       show;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] alpha;
    } t_cmd;

endpackage

`default_nettype wire

// ----- src/positioned_alpha_overlay_blend.sv -----
// A blend passes from the queue through the store read, sum and output registers; a load
// writes the overlay store when popped. Throughput: one transaction per cycle while the
// output is not stalled, set by one store access (write or read) per cycle in the back
// pipeline; a 4-entry queue between classifier and blender absorbs stalls.
// Reset (synchronous, active low) empties the queue and pipeline and clears the window
// registers to 0; the overlay store is not cleared and holds nothing until written.
`default_nettype none

module positioned_alpha_overlay_blend #(
    parameter int OVERLAY_MAX_WIDTH  = pab_pkg::OVERLAY_MAX_WIDTH,
    parameter int OVERLAY_MAX_HEIGHT = pab_pkg::OVERLAY_MAX_HEIGHT,
    parameter int FRAME_MAX_DIM      = pab_pkg::FRAME_MAX_DIM
) (
    input  wire  logic                              i_clk,
    input  wire  logic                              i_rst_n,
    input  wire  logic                              i_valid,
    output logic                                    o_ready,
    input  wire  pab_pkg::t_in_item                 i_data,
    output logic                                    o_valid,
    input  wire  logic                              i_ready,
    output pab_pkg::t_out_item                      o_data,
    input  wire  logic                              i_cfg_we,
    input  wire  logic [1:0]                        i_cfg_index,
    input  wire  logic [pab_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    import pab_pkg::*;

    localparam int AW      = $clog2(OVERLAY_MAX_WIDTH * OVERLAY_MAX_HEIGHT);
    localparam int QW      = $bits(t_cmd) + AW;
    localparam int Q_DEPTH = 4;

    t_cfg          r_cfg;
    logic          push, pop, q_full, q_empty;
    t_cmd          f_cmd, b_cmd;
    logic [AW-1:0] f_addr, b_addr;

    // Window registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_LEFT:   r_cfg.left   <= i_cfg_data[12:0];
                CFG_TOP:    r_cfg.top    <= i_cfg_data[12:0];
                CFG_WIDTH:  r_cfg.width  <= i_cfg_data[8:0];
                CFG_HEIGHT: r_cfg.height <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    pab_front #(
        .OVERLAY_MAX_WIDTH  (OVERLAY_MAX_WIDTH),
        .OVERLAY_MAX_HEIGHT (OVERLAY_MAX_HEIGHT),
        .FRAME_MAX_DIM      (FRAME_MAX_DIM)
    ) u_front (
        .i_data  (i_data),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_cfg   (r_cfg),
        .i_full  (q_full),
        .o_push  (push),
        .o_cmd   (f_cmd),
        .o_addr  (f_addr)
    );

    pab_fifo #(
        .WIDTH (QW),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata ({f_cmd, f_addr}),
        .i_pop   (pop),
        .o_rdata ({b_cmd, b_addr}),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    pab_back #(
        .OVERLAY_MAX_WIDTH  (OVERLAY_MAX_WIDTH),
        .OVERLAY_MAX_HEIGHT (OVERLAY_MAX_HEIGHT)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (b_cmd),
        .i_addr  (b_addr),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule

`default_nettype wire

// ----- src/pab_ram.sv -----
`default_nettype none

module pab_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 65536,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- src/pab_fifo.sv -----
`default_nettype none

module pab_fifo #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 4,
    localparam int PW    = $clog2(DEPTH),
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_rdata,
    output logic                  o_full,
    output logic                  o_empty
);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;

    // Advance pointers with wrap at the queue depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Hold entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_wdata;
        end
    end

    assign o_rdata = r_slot[r_rd_ptr];
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);

endmodule

`default_nettype wire

// ----- src/pab_front.sv -----
`default_nettype none

module pab_front #(
    parameter  int OVERLAY_MAX_WIDTH  = pab_pkg::OVERLAY_MAX_WIDTH,
    parameter  int OVERLAY_MAX_HEIGHT = pab_pkg::OVERLAY_MAX_HEIGHT,
    parameter  int FRAME_MAX_DIM      = pab_pkg::FRAME_MAX_DIM,
    localparam int AW = $clog2(OVERLAY_MAX_WIDTH * OVERLAY_MAX_HEIGHT)
) (
    input  wire  pab_pkg::t_in_item i_data,
    input  wire  logic              i_valid,
    output logic                    o_ready,
    input  wire  pab_pkg::t_cfg     i_cfg,
    input  wire  logic              i_full,
    output logic                    o_push,
    output pab_pkg::t_cmd           o_cmd,
    output logic [AW-1:0]           o_addr
);

    import pab_pkg::*;

    localparam int XW = $clog2(OVERLAY_MAX_WIDTH);
    localparam int YW = $clog2(OVERLAY_MAX_HEIGHT);
    localparam logic [13:0] LIM_W     = 14'(OVERLAY_MAX_WIDTH);
    localparam logic [13:0] LIM_H     = 14'(OVERLAY_MAX_HEIGHT);
    localparam logic [13:0] LIM_FRAME = 14'(FRAME_MAX_DIM);

    logic signed [13:0] fx, fy;
    logic               in_frame, in_win_x, in_win_y, load_ok;
    logic [XW-1:0]      sel_x;
    logic [YW-1:0]      sel_y;

    // Position of the pixel relative to the overlay's top-left corner
    assign fx = $signed({2'b00, i_data.column}) - $signed({i_cfg.left[12], i_cfg.left});
    assign fy = $signed({2'b00, i_data.row})    - $signed({i_cfg.top[12], i_cfg.top});

    assign in_frame = ({2'b00, i_data.column} < LIM_FRAME) && ({2'b00, i_data.row} < LIM_FRAME);

    // Window test against the width and height, clipped to the store size
    assign in_win_x = !fx[13] && ({1'b0, fx[12:0]} < {5'b0, i_cfg.width})
                      && ({1'b0, fx[12:0]} < LIM_W);
    assign in_win_y = !fy[13] && ({1'b0, fy[12:0]} < {5'b0, i_cfg.height})
                      && ({1'b0, fy[12:0]} < LIM_H);

    // Drop loads that fall outside the store
    assign load_ok = ({2'b00, i_data.column} < LIM_W) && ({2'b00, i_data.row} < LIM_H);

    // Store address: load coordinates or window offset
    always_comb begin
        if (i_data.opcode == OP_LOAD) begin
            sel_x = i_data.column[XW-1:0];
            sel_y = i_data.row[YW-1:0];
        end else begin
            sel_x = fx[XW-1:0];
            sel_y = fy[YW-1:0];
        end
    end

    assign o_addr = AW'(AW'(sel_y) * AW'(OVERLAY_MAX_WIDTH)) + AW'(sel_x);

    always_comb begin
        o_cmd.is_load = (i_data.opcode == OP_LOAD);
        o_cmd.show    = in_frame && in_win_x && in_win_y;
        o_cmd.blue    = i_data.blue_in;
        o_cmd.green   = i_data.green_in;
        o_cmd.red     = i_data.red_in;
        o_cmd.alpha   = i_data.alpha_in;
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full && ((i_data.opcode == OP_BLEND) || load_ok);

endmodule

`default_nettype wire

// ----- src/pab_back.sv -----
`default_nettype none

module pab_back #(
    parameter  int OVERLAY_MAX_WIDTH  = pab_pkg::OVERLAY_MAX_WIDTH,
    parameter  int OVERLAY_MAX_HEIGHT = pab_pkg::OVERLAY_MAX_HEIGHT,
    localparam int DEPTH = OVERLAY_MAX_WIDTH * OVERLAY_MAX_HEIGHT,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire  logic               i_clk,
    input  wire  logic               i_rst_n,
    input  wire  pab_pkg::t_cmd      i_cmd,
    input  wire  logic [AW-1:0]      i_addr,
    input  wire  logic               i_empty,
    output logic                     o_pop,
    output logic                     o_valid,
    input  wire  logic               i_ready,
    output pab_pkg::t_out_item       o_data
);

    import pab_pkg::*;

    // Floor division by 255, exact for sums up to 255*255
    function automatic logic [7:0] div255(input logic [15:0] s);
        logic [16:0] t;
        t = {1'b0, s} + 17'd1 + {9'b0, s[15:8]};
        return t[15:8];
    endfunction

    logic        en;
    logic [31:0] rd_entry;

    logic        r_s1_valid;
    logic        r_s1_show;
    logic [7:0]  r_s1_b, r_s1_g, r_s1_r;

    logic        r_s2_valid;
    logic        r_s2_use;
    logic [7:0]  r_s2_b, r_s2_g, r_s2_r;
    logic [15:0] r_s2_sum_b, r_s2_sum_g, r_s2_sum_r;
    logic [15:0] n_sum_b, n_sum_g, n_sum_r;
    logic [7:0]  fa, inv_a;

    logic        r_out_valid;
    t_out_item   r_out;

    // Advance the whole back pipeline unless the result is stalled
    assign en    = !r_out_valid || i_ready;
    assign o_pop = en && !i_empty;

    pab_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (o_pop && i_cmd.is_load),
        .i_waddr (i_addr),
        .i_wdata ({i_cmd.alpha, i_cmd.red, i_cmd.green, i_cmd.blue}),
        .i_re    (en),
        .i_raddr (i_addr),
        .o_rdata (rd_entry)
    );

    // Store read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= o_pop && !i_cmd.is_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_show <= i_cmd.show;
            r_s1_b    <= i_cmd.blue;
            r_s1_g    <= i_cmd.green;
            r_s1_r    <= i_cmd.red;
        end
    end

    // Weighted sums of background and overlay
    assign fa    = rd_entry[31:24];
    assign inv_a = 8'd255 - fa;
    assign n_sum_b = 16'(16'(r_s1_b) * 16'(inv_a)) + 16'(16'(rd_entry[7:0])   * 16'(fa));
    assign n_sum_g = 16'(16'(r_s1_g) * 16'(inv_a)) + 16'(16'(rd_entry[15:8])  * 16'(fa));
    assign n_sum_r = 16'(16'(r_s1_r) * 16'(inv_a)) + 16'(16'(rd_entry[23:16]) * 16'(fa));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_use   <= r_s1_show && (fa != 8'd0);
            r_s2_b     <= r_s1_b;
            r_s2_g     <= r_s1_g;
            r_s2_r     <= r_s1_r;
            r_s2_sum_b <= n_sum_b;
            r_s2_sum_g <= n_sum_g;
            r_s2_sum_r <= n_sum_r;
        end
    end

    // Output register: blended pixel or background passed through
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_s2_use) begin
                r_out.blue_out  <= div255(r_s2_sum_b);
                r_out.green_out <= div255(r_s2_sum_g);
                r_out.red_out   <= div255(r_s2_sum_r);
            end else begin
                r_out.blue_out  <= r_s2_b;
                r_out.green_out <= r_s2_g;
                r_out.red_out   <= r_s2_r;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

// ----- src/pab_checker.sv -----
`default_nettype none

module pab_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_valid,
    input wire logic               o_ready,
    input wire pab_pkg::t_in_item  i_data,
    input wire logic               o_valid,
    input wire logic               i_ready,
    input wire pab_pkg::t_out_item o_data
);

    import pab_pkg::*;

    // Queue depth plus three back stages
    localparam logic [3:0] MAX_OUTSTANDING = 4'd7;

    logic       in_blend, out_xfer;
    logic [3:0] r_pending;

    assign in_blend = i_valid && o_ready && (i_data.opcode == OP_BLEND);
    assign out_xfer = o_valid && i_ready;

    // Track blend transactions not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (in_blend && !out_xfer) begin
            r_pending <= r_pending + 1'b1;
        end else if (!in_blend && out_xfer) begin
            r_pending <= r_pending - 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_pending != 4'd0)
        else $error("result with no blend outstanding");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= MAX_OUTSTANDING)
        else $error("more blends in flight than the block can hold");

endmodule

bind positioned_alpha_overlay_blend pab_checker u_pab_checker (.*);

`default_nettype wire

// ----- dv/positioned_alpha_overlay_blend_test.sv -----
module positioned_alpha_overlay_blend_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pab_pkg::*;

    localparam int STORE_DEPTH   = OVERLAY_MAX_WIDTH * OVERLAY_MAX_HEIGHT;
    localparam int PHASE_ITEMS   = 150;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;

    // Predicts output pixels from accepted transactions and checks the results
    class blend_scoreboard;
        logic [31:0] overlay_copy [STORE_DEPTH];
        t_cfg        window = '0;
        t_out_item   expected_pixels [$];
        int          errors = 0;

        function void write_register(t_cfg_index idx, logic [12:0] value);
            case (idx)
                CFG_LEFT:   window.left   = value;
                CFG_TOP:    window.top    = value;
                CFG_WIDTH:  window.width  = value[8:0];
                CFG_HEIGHT: window.height = value[8:0];
                default: ;
            endcase
        endfunction

        // Saturate the window at the size of the overlay store
        function int cols_in_use();
            return (window.width > OVERLAY_MAX_WIDTH) ? OVERLAY_MAX_WIDTH : int'(window.width);
        endfunction

        function int rows_in_use();
            return (window.height > OVERLAY_MAX_HEIGHT) ?
                   OVERLAY_MAX_HEIGHT : int'(window.height);
        endfunction

        // Map a frame position to its overlay entry; 0 when it lies outside the window or the frame
        function bit window_entry(logic [11:0] col, logic [11:0] row, output int addr);
            int fx;
            int fy;
            addr = 0;
            if (int'(col) >= FRAME_MAX_DIM || int'(row) >= FRAME_MAX_DIM)
                return 1'b0;
            fx = int'(col) - int'($signed(window.left));
            fy = int'(row) - int'($signed(window.top));
            if (fx < 0 || fy < 0 || fx >= cols_in_use() || fy >= rows_in_use())
                return 1'b0;
            addr = fy * OVERLAY_MAX_WIDTH + fx;
            return 1'b1;
        endfunction

        function logic [7:0] mix_channel(int bg, int fg, int alpha);
            return 8'((bg * (255 - alpha) + fg * alpha) / 255);
        endfunction

        function t_out_item blend_pixel(t_in_item px);
            t_out_item   res;
            int          addr;
            logic [31:0] entry;
            res.blue_out  = px.blue_in;
            res.green_out = px.green_in;
            res.red_out   = px.red_in;
            if (window_entry(px.column, px.row, addr)) begin
                entry = overlay_copy[addr];
                // Fully transparent entries leave the background alone
                if (entry[31:24] != 8'd0) begin
                    res.blue_out  = mix_channel(px.blue_in,  entry[7:0],   entry[31:24]);
                    res.green_out = mix_channel(px.green_in, entry[15:8],  entry[31:24]);
                    res.red_out   = mix_channel(px.red_in,   entry[23:16], entry[31:24]);
                end
            end
            return res;
        endfunction

        function void note_transaction(t_in_item item);
            if (item.opcode == OP_LOAD) begin
                if (int'(item.column) < OVERLAY_MAX_WIDTH && int'(item.row) < OVERLAY_MAX_HEIGHT)
                    overlay_copy[int'(item.row) * OVERLAY_MAX_WIDTH + int'(item.column)] =
                        {item.alpha_in, item.red_in, item.green_in, item.blue_in};
            end else begin
                expected_pixels.push_back(blend_pixel(item));
            end
        endfunction

        function void compare_channel(string name, logic [7:0] exp_val, logic [7:0] act_val);
            if (exp_val !== act_val) begin
                errors++;
                $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            end
        endfunction

        function void check_pixel(t_out_item got);
            t_out_item exp_px;
            if (expected_pixels.size() == 0) begin
                errors++;
                $error("output pixel with no transaction pending: %h", got);
                return;
            end
            exp_px = expected_pixels.pop_front();
            compare_channel("blue_out",  exp_px.blue_out,  got.blue_out);
            compare_channel("green_out", exp_px.green_out, got.green_out);
            compare_channel("red_out",   exp_px.red_out,   got.red_out);
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       in_valid;
    logic       o_ready;
    t_in_item   in_data;
    logic       o_valid;
    logic       out_ready;
    t_out_item  o_data;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    blend_scoreboard sb = new();
    bit overlay_written [STORE_DEPTH];
    bit steady_flow  = 1'b0;
    bit hold_request = 1'b0;
    int cycle_count  = 0;

    positioned_alpha_overlay_blend dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_valid),
        .o_ready     (o_ready),
        .i_data      (in_data),
        .o_valid     (o_valid),
        .i_ready     (out_ready),
        .o_data      (o_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Note accepted transactions and check results at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && in_valid && o_ready)
            sb.note_transaction(in_data);
        if (i_rst_n && o_valid && out_ready)
            sb.check_pixel(o_data);
    end

    // Abort a run that hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: draw a stall per result, or hold off for a long stretch on request
    initial begin
        int stall;
        out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = steady_flow ? 0 : int'($urandom_range(3, 0));
            if (hold_request) begin
                stall        = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            @(negedge i_clk);
        end
    end

    function automatic logic [7:0] random_level();
        case ($urandom_range(3, 0))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Offer one transaction and hold it until accepted; returns at a falling edge
    task automatic send_item(t_in_item item);
        int gap = steady_flow ? 0 : int'($urandom_range(3, 0));
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        @(negedge i_clk);
    endtask

    task automatic send_load(int col, int row, logic [7:0] blue, logic [7:0] green,
                             logic [7:0] red, logic [7:0] alpha);
        t_in_item item;
        item.opcode   = OP_LOAD;
        item.column   = 12'(col);
        item.row      = 12'(row);
        item.blue_in  = blue;
        item.green_in = green;
        item.red_in   = red;
        item.alpha_in = alpha;
        if (col < OVERLAY_MAX_WIDTH && row < OVERLAY_MAX_HEIGHT)
            overlay_written[row * OVERLAY_MAX_WIDTH + col] = 1'b1;
        send_item(item);
    endtask

    // Load the overlay entry first when the blend would read one never written
    task automatic send_blend(int col, int row, logic [7:0] blue, logic [7:0] green,
                              logic [7:0] red);
        t_in_item item;
        int       addr;
        if (sb.window_entry(12'(col), 12'(row), addr) && !overlay_written[addr])
            send_load(addr % OVERLAY_MAX_WIDTH, addr / OVERLAY_MAX_WIDTH,
                      random_level(), random_level(), random_level(), random_level());
        item.opcode   = OP_BLEND;
        item.column   = 12'(col);
        item.row      = 12'(row);
        item.blue_in  = blue;
        item.green_in = green;
        item.red_in   = red;
        item.alpha_in = 8'($urandom);
        send_item(item);
    endtask

    // Drop valid and let every pending result and load drain out
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (sb.expected_pixels.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_register(t_cfg_index idx, logic [12:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        sb.write_register(idx, value);
        @(negedge i_clk);
    endtask

    // Upper data bits of the size registers are junk and must be ignored
    task automatic apply_window(int left, int top, int width, int height);
        wait_for_results();
        set_register(CFG_LEFT, 13'(left));
        set_register(CFG_TOP, 13'(top));
        set_register(CFG_WIDTH, {4'($urandom), 9'(width)});
        set_register(CFG_HEIGHT, {4'($urandom), 9'(height)});
        cfg_we <= 1'b0;
    endtask

    task automatic random_item();
        int pick;
        int cols;
        int rows;
        int lft;
        int tp;
        int lo_c;
        int hi_c;
        int lo_r;
        int hi_r;
        bit visible;
        pick = int'($urandom_range(99, 0));
        cols = sb.cols_in_use();
        rows = sb.rows_in_use();
        lft  = int'($signed(sb.window.left));
        tp   = int'($signed(sb.window.top));
        lo_c = (lft > 0) ? lft : 0;
        lo_r = (tp > 0) ? tp : 0;
        hi_c = lft + cols - 1;
        hi_r = tp + rows - 1;
        if (hi_c > FRAME_MAX_DIM - 1) hi_c = FRAME_MAX_DIM - 1;
        if (hi_r > FRAME_MAX_DIM - 1) hi_r = FRAME_MAX_DIM - 1;
        visible = cols > 0 && rows > 0 && lo_c <= hi_c && lo_r <= hi_r;

        if (pick < 55 && visible) begin
            // blend on the visible part of the overlay
            send_blend(int'($urandom_range(hi_c, lo_c)), int'($urandom_range(hi_r, lo_r)),
                       random_level(), random_level(), random_level());
        end else if (pick < 70 && cols > 0 && rows > 0) begin
            // refresh an overlay entry inside the window
            send_load(int'($urandom_range(cols - 1, 0)), int'($urandom_range(rows - 1, 0)),
                      random_level(), random_level(), random_level(), random_level());
        end else if (pick < 80) begin
            // load anywhere, mostly out of range and so dropped
            send_load($urandom_range(1, 0) ? int'($urandom_range(511, 0))
                                           : int'($urandom_range(4095, 0)),
                      $urandom_range(1, 0) ? int'($urandom_range(511, 0))
                                           : int'($urandom_range(4095, 0)),
                      8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end else begin
            send_blend(int'($urandom_range(4095, 0)), int'($urandom_range(4095, 0)),
                       8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    task automatic run_phase(int left, int top, int width, int height, bit steady, bit hold);
        apply_window(left, top, width, height);
        steady_flow  = steady;
        hold_request = hold;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            // pause the sender half way until the block has emptied
            if (n == PHASE_ITEMS / 2)
                wait_for_results();
            random_item();
        end
    endtask

    initial begin
        i_rst_n   = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Oversized window placed above and left of the frame
        apply_window(-2, -3, 511, 300);
        send_load(2, 3, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_load(3, 3, 8'h00, 8'h00, 8'h00, 8'h00);
        send_load(4, 3, 8'h00, 8'h80, 8'hFF, 8'h80);
        send_load(255, 255, 8'h01, 8'h02, 8'h03, 8'hC8);
        send_load(256, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_load(0, 256, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_load(4095, 4095, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_blend(0, 0, 8'h00, 8'h00, 8'h00);
        send_blend(1, 0, 8'h12, 8'h34, 8'h56);
        send_blend(2, 0, 8'hFF, 8'h00, 8'hFF);
        send_blend(253, 252, 8'hFF, 8'hFF, 8'hFF);
        send_blend(254, 252, 8'hAA, 8'h55, 8'hAA);
        send_blend(4095, 4095, 8'hFF, 8'h00, 8'h7F);

        // Zero-sized windows pass every pixel
        apply_window(0, 0, 0, 256);
        send_blend(0, 0, 8'h11, 8'h22, 8'h33);
        send_blend(5, 5, 8'hFE, 8'h01, 8'h80);
        apply_window(0, 0, 256, 0);
        send_blend(0, 0, 8'h44, 8'h55, 8'h66);

        // One-pixel window in the far corner of the frame
        apply_window(4095, 4095, 1, 1);
        send_load(0, 0, 8'h00, 8'hFF, 8'h00, 8'hFF);
        send_blend(4095, 4095, 8'hFF, 8'h00, 8'hFF);
        send_blend(4094, 4095, 8'h01, 8'h02, 8'h03);

        // Random phases across window settings
        run_phase(-4096, -4096, 256, 256, 1'b0, 1'b0);
        run_phase(-100, -50, 256, 200, 1'b0, 1'b1);
        run_phase(4095, 4095, 511, 511, 1'b1, 1'b0);
        run_phase(int'($urandom_range(4200, 0)) - 300, int'($urandom_range(4200, 0)) - 300,
                  int'($urandom_range(256, 1)), int'($urandom_range(256, 1)), 1'b0, 1'b0);
        run_phase(0, 0, 0, int'($urandom_range(511, 0)), 1'b1, 1'b0);
        run_phase(3900, 3950, 300, 257, 1'b0, 1'b0);
        run_phase(int'($urandom_range(4395, 0)) - 300, int'($urandom_range(4395, 0)) - 300,
                  int'($urandom_range(511, 0)), int'($urandom_range(511, 0)), 1'b1, 1'b0);
        run_phase(0, 0, 16, 16, 1'b0, 1'b1);

        wait_for_results();
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
